/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/sats_pkg.sv */
// types and constants of the solenoid actuation test sequencer
package sats_pkg;

  localparam int LEVEL_W    = 8;
  localparam int MS_W       = 10;
  localparam int DUR_W      = 9;
  localparam int INTERVAL_W = 10;
  localparam int PHASE_W    = 3;
  localparam int TIMER_W    = 16;
  localparam int TOTAL_W    = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 112;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PULL_LEVEL    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LEVEL    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PULL_TIME_MS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ON_WINDOW_MS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_WINDOW_MS = 3'd4;

  // register reset values
  localparam logic [LEVEL_W-1:0] PULL_LEVEL_RST    = 8'd255;
  localparam logic [LEVEL_W-1:0] HOLD_LEVEL_RST    = 8'd100;
  localparam logic [MS_W-1:0]    PULL_TIME_MS_RST  = 10'd100;
  localparam logic [MS_W-1:0]    ON_WINDOW_MS_RST  = 10'd100;
  localparam logic [MS_W-1:0]    OFF_WINDOW_MS_RST = 10'd200;

  // input item kinds
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  typedef enum logic [PHASE_W-1:0] {
    PH_WAIT       = 3'd0,
    PH_DETECT_ON  = 3'd1,
    PH_PULL_REST  = 3'd2,
    PH_HOLD       = 3'd3,
    PH_DETECT_OFF = 3'd4
  } phase_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pull_level;
    logic [LEVEL_W-1:0] hold_level;
    logic [MS_W-1:0]    pull_time_ms;
    logic [MS_W-1:0]    on_window_ms;
    logic [MS_W-1:0]    off_window_ms;
  } cfg_t;

  typedef struct packed {
    logic                  command;
    logic [DUR_W-1:0]      on_duration;
    logic [INTERVAL_W-1:0] next_interval;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive_level;
    phase_t             phase;
    logic               test_done;
    logic               test_passed;
    logic [TOTAL_W-1:0] test_number;
    logic [TOTAL_W-1:0] passed_total;
    logic [TOTAL_W-1:0] failed_total;
  } result_t;

endpackage

/* rtl/core/sats_cfg.sv */
// configuration registers of the sequencer
module sats_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [sats_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sats_pkg::CFG_DATA_W-1:0]    cfg_data,
  output sats_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pull_level    <= sats_pkg::PULL_LEVEL_RST;
      cfg.hold_level    <= sats_pkg::HOLD_LEVEL_RST;
      cfg.pull_time_ms  <= sats_pkg::PULL_TIME_MS_RST;
      cfg.on_window_ms  <= sats_pkg::ON_WINDOW_MS_RST;
      cfg.off_window_ms <= sats_pkg::OFF_WINDOW_MS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sats_pkg::REG_PULL_LEVEL:    cfg.pull_level    <= cfg_data[sats_pkg::LEVEL_W-1:0];
        sats_pkg::REG_HOLD_LEVEL:    cfg.hold_level    <= cfg_data[sats_pkg::LEVEL_W-1:0];
        sats_pkg::REG_PULL_TIME_MS:  cfg.pull_time_ms  <= cfg_data[sats_pkg::MS_W-1:0];
        sats_pkg::REG_ON_WINDOW_MS:  cfg.on_window_ms  <= cfg_data[sats_pkg::MS_W-1:0];
        sats_pkg::REG_OFF_WINDOW_MS: cfg.off_window_ms <= cfg_data[sats_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/sats_engine.sv */
// test phase state, timers and counters, updated once per item
`include "assert_macros.svh"

module sats_engine #(
  parameter int INITIAL_INTERVAL_MS = 500,
  parameter int COUNT_BITS          = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  sats_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  sats_pkg::item_t   item,
  output sats_pkg::result_t result
);

  sats_pkg::phase_t                      phase, phase_next;
  logic [sats_pkg::TIMER_W-1:0]          timer, timer_next;
  logic [sats_pkg::INTERVAL_W-1:0]       wait_interval, wait_interval_next;
  logic [sats_pkg::DUR_W-1:0]            hold_target, hold_target_next;
  logic                                  saw_on, saw_on_next;
  logic                                  saw_off, saw_off_next;
  logic [COUNT_BITS-1:0]                 tests_total, tests_total_next;
  logic [COUNT_BITS-1:0]                 passes_total, passes_total_next;
  logic [COUNT_BITS-1:0]                 fails_total, fails_total_next;
  logic                                  settle;
  logic                                  finish;
  logic                                  done;
  logic                                  passed;
  logic [sats_pkg::LEVEL_W-1:0]          drive;

  // next state
  always_comb begin
    phase_next         = phase;
    timer_next         = timer;
    wait_interval_next = wait_interval;
    hold_target_next   = hold_target;
    saw_on_next        = saw_on;
    saw_off_next       = saw_off;
    tests_total_next   = tests_total;
    passes_total_next  = passes_total;
    fails_total_next   = fails_total;
    settle             = 1'b0;
    finish             = 1'b0;
    done               = 1'b0;
    passed             = 1'b0;
    if (item_valid) begin
      if (item.command == sats_pkg::CMD_TICK) begin
        if (timer != '1) begin
          timer_next = timer + 1'b1;
        end
        if (phase == sats_pkg::PH_WAIT &&
            timer_next >= sats_pkg::TIMER_W'(wait_interval)) begin
          phase_next       = sats_pkg::PH_DETECT_ON;
          timer_next       = '0;
          hold_target_next = item.on_duration;
          saw_on_next      = 1'b0;
          saw_off_next     = 1'b0;
        end
        settle = 1'b1;
      end else begin
        case (phase)
          sats_pkg::PH_DETECT_ON: begin
            saw_on_next = 1'b1;
            phase_next  = sats_pkg::PH_PULL_REST;
            settle      = 1'b1;
          end
          sats_pkg::PH_DETECT_OFF: begin
            saw_off_next = 1'b1;
            finish       = 1'b1;
          end
          default: ;
        endcase
      end

      // fall through every phase whose limit is already reached
      if (settle) begin
        if (phase_next == sats_pkg::PH_DETECT_ON &&
            timer_next >= sats_pkg::TIMER_W'(cfg.on_window_ms)) begin
          phase_next = sats_pkg::PH_PULL_REST;
        end
        if (phase_next == sats_pkg::PH_PULL_REST &&
            timer_next >= sats_pkg::TIMER_W'(cfg.pull_time_ms)) begin
          phase_next = sats_pkg::PH_HOLD;
          timer_next = '0;
        end
        if (phase_next == sats_pkg::PH_HOLD &&
            timer_next >= sats_pkg::TIMER_W'(hold_target_next)) begin
          phase_next = sats_pkg::PH_DETECT_OFF;
          timer_next = '0;
        end
        if (phase_next == sats_pkg::PH_DETECT_OFF &&
            timer_next >= sats_pkg::TIMER_W'(cfg.off_window_ms)) begin
          finish = 1'b1;
        end
      end

      if (finish) begin
        done             = 1'b1;
        passed           = saw_on_next && saw_off_next;
        tests_total_next = tests_total + 1'b1;
        if (passed) begin
          passes_total_next = passes_total + 1'b1;
        end else begin
          fails_total_next = fails_total + 1'b1;
        end
        phase_next         = sats_pkg::PH_WAIT;
        timer_next         = '0;
        wait_interval_next = item.next_interval;
        saw_on_next        = 1'b0;
        saw_off_next       = 1'b0;
      end
    end
  end

  // drive level follows the phase after the update
  always_comb begin
    case (phase_next)
      sats_pkg::PH_DETECT_ON,
      sats_pkg::PH_PULL_REST: drive = cfg.pull_level;
      sats_pkg::PH_HOLD:      drive = cfg.hold_level;
      default:                drive = '0;
    endcase
  end

  always_comb begin
    result.drive_level  = drive;
    result.phase        = phase_next;
    result.test_done    = done;
    result.test_passed  = passed;
    result.test_number  = sats_pkg::TOTAL_W'(tests_total_next);
    result.passed_total = sats_pkg::TOTAL_W'(passes_total_next);
    result.failed_total = sats_pkg::TOTAL_W'(fails_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sats_pkg::PH_WAIT;
      timer         <= '0;
      wait_interval <= sats_pkg::INTERVAL_W'(INITIAL_INTERVAL_MS);
      hold_target   <= '0;
      saw_on        <= 1'b0;
      saw_off       <= 1'b0;
      tests_total   <= '0;
      passes_total  <= '0;
      fails_total   <= '0;
    end else begin
      phase         <= phase_next;
      timer         <= timer_next;
      wait_interval <= wait_interval_next;
      hold_target   <= hold_target_next;
      saw_on        <= saw_on_next;
      saw_off       <= saw_off_next;
      tests_total   <= tests_total_next;
      passes_total  <= passes_total_next;
      fails_total   <= fails_total_next;
    end
  end

  `ASSERT_IMPLIES(a_pass_needs_done, clk, rst, result.test_passed, result.test_done)
  `ASSERT_NEXT(a_done_back_to_wait, clk, rst, item_valid && done,
               phase == sats_pkg::PH_WAIT && timer == '0 && !saw_on && !saw_off)
  `ASSERT_NEXT(a_idle_holds_state, clk, rst, !item_valid,
               $stable(phase) && $stable(timer) && $stable(tests_total))

endmodule

/* rtl/core/solenoid_actuation_test_sequencer.sv */
// solenoid actuation test sequencer: top level with input and result registers
//
// s_* channel: one item per transfer. s_tuser is the command (0 = 1 ms tick,
// 1 = endstop falling edge); s_tdata carries on_duration and next_interval.
// m_* channel: exactly one result per input item, in order, carrying the
// drive level, the phase, the test done/passed flags and three counters.
// cfg_* port: a write of register cfg_index with cfg_data when cfg_wr_en is
// high; write only while no item is in flight.
// path: an accepted item waits in the input register, and its result is
// registered in the result register, which drives m_tvalid.
// throughput: one item per cycle while m_tready is high; the phase and
// counter update is one pass of logic between the input register and the
// result register. if m_tready is low the result register holds and the
// input register still takes one more item; s_tready drops only when both
// are full. reset (rst, synchronous) empties both registers, restores the
// register defaults, puts the sequencer in the wait phase with an interval
// of INITIAL_INTERVAL_MS (500 ms by default) and clears all counters.
module solenoid_actuation_test_sequencer #(
  parameter int INITIAL_INTERVAL_MS = 500,
  parameter int COUNT_BITS          = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [8:0] on_duration, [18:9] next_interval, [23:19] zero
  input  logic [sats_pkg::IN_TDATA_W-1:0]      s_tdata,
  // [0] command
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [7:0] drive_level, [10:8] phase, [11] test_done, [12] test_passed,
  // [44:13] test_number, [76:45] passed_total, [108:77] failed_total,
  // [111:109] zero
  output logic [sats_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [sats_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sats_pkg::CFG_DATA_W-1:0]      cfg_data
);

  sats_pkg::cfg_t    cfg;
  sats_pkg::item_t   in_item;
  sats_pkg::result_t step_result;
  sats_pkg::result_t out_result;
  logic              in_valid;
  logic              advance;
  logic              s_accept;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  sats_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sats_engine #(
    .INITIAL_INTERVAL_MS (INITIAL_INTERVAL_MS),
    .COUNT_BITS          (COUNT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (advance),
    .item       (in_item),
    .result     (step_result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_item.command       <= s_tuser;
      in_item.on_duration   <= s_tdata[8:0];
      in_item.next_interval <= s_tdata[18:9];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {3'b000,
                    out_result.failed_total,
                    out_result.passed_total,
                    out_result.test_number,
                    out_result.test_passed,
                    out_result.test_done,
                    out_result.phase,
                    out_result.drive_level};

  `ASSERT_NEXT(a_advance_fills_output, clk, rst, advance, m_tvalid)
  `ASSERT_NEXT(a_held_item_kept, clk, rst, in_valid && !advance, in_valid && m_tvalid)

endmodule
